// ===== hw/rtl/lookahead_peak_limiter_unit_macros.svh =====
// assertion macros for the lookahead peak limiter
// no dependencies; included by the top level
`ifndef LOOKAHEAD_PEAK_LIMITER_UNIT_MACROS_SVH
`define LOOKAHEAD_PEAK_LIMITER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define LPL_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LPL_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lpl_pkg.sv =====
// shared types and constants for the lookahead peak limiter
// no dependencies
package lpl_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 24;
  localparam int COEF_W   = 24;
  localparam int THR_W    = 23;
  localparam int DLEN_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_W    = 26;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'h800000;
  localparam logic [COEF_W:0]   COEF_ONE   = 25'h1000000;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_THRESHOLD = 2'd3;

  localparam logic [DLEN_W-1:0] RST_DELAY_LENGTH   = 7'd32;
  localparam logic [COEF_W-1:0] RST_ATTACK_COEF    = 24'd15099494;
  localparam logic [COEF_W-1:0] RST_RELEASE_COEF   = 24'd16768827;
  localparam logic [THR_W-1:0]  RST_LIMIT_THRESHOLD = 23'd996147;

  localparam int DIV_STEPS = 23;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_WRITE = 10'b0000000100,
    S_ENV   = 10'b0000001000,
    S_ACC   = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_TGT   = 10'b0001000000,
    S_GAIN  = 10'b0010000000,
    S_OMUL  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

endpackage

// ===== hw/rtl/lpl_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module lpl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/lpl_div.sv =====
// restoring divider, one quotient bit per cycle: (dividend << 23) / divisor
// needs dividend < divisor; depends on lpl_pkg
module lpl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lpl_pkg::THR_W-1:0]     dividend,
  input  logic [lpl_pkg::SAMPLE_W-1:0]  divisor,
  output logic                          done,
  output logic [lpl_pkg::DIV_STEPS-1:0] quotient
);

  logic                          busy_r;
  logic                          done_r;
  logic [lpl_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [lpl_pkg::SAMPLE_W-1:0]  rem_r;
  logic [lpl_pkg::SAMPLE_W-1:0]  dsr_r;
  logic [lpl_pkg::DIV_STEPS-1:0] quo_r;
  logic [lpl_pkg::SAMPLE_W:0]    trial;
  logic                          fits;

  always_comb begin
    trial = {rem_r, 1'b0} - {1'b0, dsr_r};
    fits  = !trial[lpl_pkg::SAMPLE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + lpl_pkg::DIV_CNT_W'(1);
        if (cnt_r == lpl_pkg::DIV_CNT_W'(lpl_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      dsr_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? trial[lpl_pkg::SAMPLE_W-1:0] : {rem_r[lpl_pkg::SAMPLE_W-2:0], 1'b0};
      quo_r <= {quo_r[lpl_pkg::DIV_STEPS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/lookahead_peak_limiter_unit.sv =====
// Lookahead peak limiter: one interleaved Q4.20 sample in, one limited sample
// out. Each word runs through the write, envelope, accumulate, target, gain,
// multiply and output states; when the envelope exceeds the threshold it also
// waits for the bit-serial gain divider (23 quotient bits, one per cycle);
// all products go through one shared 26x26 multiplier in turn. in_tready is
// high only between words. After reset the delay ram is zeroed in a pass over
// its CHANNELS*DELAY_MAX entries before the first word is taken; configuration
// writes are accepted only between words and go ahead of a waiting word.
// Depends on lpl_pkg, lpl_ram, lpl_div and
// lookahead_peak_limiter_unit_macros.svh.
`include "lookahead_peak_limiter_unit_macros.svh"

module lookahead_peak_limiter_unit #(
  parameter int CHANNELS  = 2,
  parameter int DELAY_MAX = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lpl_pkg::SAMPLE_W-1:0]    in_tdata,   // [23:0] sample
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lpl_pkg::SAMPLE_W-1:0]    out_tdata,  // [23:0] limited_sample
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpl_pkg::COEF_W-1:0]      cfg_data
);

  localparam int DEPTH = CHANNELS * DELAY_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(DELAY_MAX);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW    = (SW + 1 > lpl_pkg::DLEN_W) ? SW + 1 : lpl_pkg::DLEN_W;
  localparam int SMW   = lpl_pkg::SAMPLE_W;
  localparam int MW    = lpl_pkg::MUL_W;

  lpl_pkg::state_t state_r, state_nxt;

  // configuration
  logic [lpl_pkg::DLEN_W-1:0] dlen_r;
  logic [lpl_pkg::COEF_W-1:0] atk_r;
  logic [lpl_pkg::COEF_W-1:0] rel_r;
  logic [lpl_pkg::THR_W-1:0]  thr_r;

  // position state
  logic [CW-1:0] ch_r;
  logic [SW-1:0] wp_r;
  logic [AW-1:0] clr_cnt_r;

  // per-word working registers
  logic [CW-1:0]     cur_ch_r;
  logic [SW-1:0]     wslot_r;
  logic [SW-1:0]     rslot_r;
  logic [SMW-1:0]    sample_r;
  logic [SMW-1:0]    target_r;
  logic [SMW-1:0]    acc_r;
  logic              need_div_r;
  logic signed [2*MW-1:0] prod_r;

  logic [SMW-1:0] env_r  [CHANNELS];
  logic [SMW-1:0] gain_r [CHANNELS];

  logic              out_valid_r;
  logic [SMW-1:0]    out_data_r;

  // slot arithmetic
  logic [LW-1:0] dlen_ext;
  logic [LW-1:0] len;
  logic [SW-1:0] wslot;
  logic [SW-1:0] rslot;
  logic          last_ch;

  always_comb begin
    dlen_ext = LW'(dlen_r);
    if (dlen_ext == '0) begin
      len = LW'(1);
    end else if (dlen_ext > LW'(DELAY_MAX)) begin
      len = LW'(DELAY_MAX);
    end else begin
      len = dlen_ext;
    end
    wslot   = (LW'(wp_r) >= len) ? '0 : wp_r;
    rslot   = (LW'(wslot) + LW'(1) >= len) ? '0 : wslot + SW'(1);
    last_ch = (ch_r == CW'(CHANNELS - 1));
  end

  function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] ch,
                                               input logic [SW-1:0] slot);
    logic [AW:0] full;
    full = (AW + 1)'(ch) * (AW + 1)'(DELAY_MAX) + (AW + 1)'(slot);
    return full[AW-1:0];
  endfunction

  // delay store
  logic           ram_wr_en;
  logic [AW-1:0]  ram_wr_addr;
  logic [SMW-1:0] ram_wr_data;
  logic           ram_rd_en;
  logic [SMW-1:0] ram_rd_data;

  assign ram_wr_en   = (state_r == lpl_pkg::S_CLEAR) || (state_r == lpl_pkg::S_WRITE);
  assign ram_wr_addr = (state_r == lpl_pkg::S_CLEAR) ? clr_cnt_r : slot_addr(cur_ch_r, wslot_r);
  assign ram_wr_data = (state_r == lpl_pkg::S_CLEAR) ? '0 : sample_r;
  assign ram_rd_en   = (state_r == lpl_pkg::S_ENV);

  lpl_ram #(
    .WIDTH (SMW),
    .DEPTH (DEPTH)
  ) u_delay_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (slot_addr(cur_ch_r, rslot_r)),
    .rd_data (ram_rd_data)
  );

  // envelope and gain
  logic [SMW-1:0] mag;
  logic [SMW-1:0] env_new;
  logic [SMW:0]   gain_sum;
  logic           div_start;
  logic           div_done;
  logic [lpl_pkg::DIV_STEPS-1:0] div_quo;

  always_comb begin
    mag      = sample_r[SMW-1] ? (~sample_r + SMW'(1)) : sample_r;
    env_new  = (mag > prod_r[47:24]) ? mag : prod_r[47:24];
    gain_sum = {1'b0, acc_r} + {1'b0, prod_r[47:24]};
  end

  assign div_start = (state_r == lpl_pkg::S_ENV) && (env_new > {1'b0, thr_r});

  lpl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (thr_r),
    .divisor  (env_new),
    .done     (div_done),
    .quotient (div_quo)
  );

  // shared multiplier operands
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;

  always_comb begin
    case (state_r)
      lpl_pkg::S_WRITE: begin
        mul_a = MW'(env_r[cur_ch_r]);
        mul_b = MW'(rel_r);
      end
      lpl_pkg::S_ENV: begin
        mul_a = MW'(gain_r[cur_ch_r]);
        mul_b = MW'(atk_r);
      end
      lpl_pkg::S_TGT: begin
        mul_a = MW'(target_r);
        mul_b = MW'(lpl_pkg::COEF_ONE - {1'b0, atk_r});
      end
      lpl_pkg::S_OMUL, lpl_pkg::S_OUT: begin
        mul_a = {{(MW - SMW){ram_rd_data[SMW-1]}}, ram_rd_data};
        mul_b = MW'(gain_r[cur_ch_r]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpl_pkg::S_CLEAR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = lpl_pkg::S_IDLE;
      end
      lpl_pkg::S_IDLE: begin
        if (in_tvalid && in_tready) state_nxt = lpl_pkg::S_WRITE;
      end
      lpl_pkg::S_WRITE: state_nxt = lpl_pkg::S_ENV;
      lpl_pkg::S_ENV:   state_nxt = lpl_pkg::S_ACC;
      lpl_pkg::S_ACC:   state_nxt = need_div_r ? lpl_pkg::S_DIV : lpl_pkg::S_TGT;
      lpl_pkg::S_DIV: begin
        if (div_done) state_nxt = lpl_pkg::S_TGT;
      end
      lpl_pkg::S_TGT:   state_nxt = lpl_pkg::S_GAIN;
      lpl_pkg::S_GAIN:  state_nxt = lpl_pkg::S_OMUL;
      lpl_pkg::S_OMUL:  state_nxt = lpl_pkg::S_OUT;
      lpl_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = lpl_pkg::S_IDLE;
      end
      default: state_nxt = lpl_pkg::S_CLEAR;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpl_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      ch_r        <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
      dlen_r      <= lpl_pkg::RST_DELAY_LENGTH;
      atk_r       <= lpl_pkg::RST_ATTACK_COEF;
      rel_r       <= lpl_pkg::RST_RELEASE_COEF;
      thr_r       <= lpl_pkg::RST_LIMIT_THRESHOLD;
      for (int i = 0; i < CHANNELS; i++) begin
        env_r[i]  <= '0;
        gain_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == lpl_pkg::S_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (in_tvalid && in_tready) begin
        ch_r <= last_ch ? '0 : ch_r + CW'(1);
        wp_r <= last_ch ? rslot : wslot;
      end
      if (state_r == lpl_pkg::S_ENV) env_r[cur_ch_r] <= env_new;
      if (state_r == lpl_pkg::S_GAIN) gain_r[cur_ch_r] <= gain_sum[SMW-1:0];
      if (state_r == lpl_pkg::S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lpl_pkg::REG_DELAY_LENGTH:    dlen_r <= cfg_data[lpl_pkg::DLEN_W-1:0];
          lpl_pkg::REG_ATTACK_COEF:     atk_r  <= cfg_data;
          lpl_pkg::REG_RELEASE_COEF:    rel_r  <= cfg_data;
          lpl_pkg::REG_LIMIT_THRESHOLD: thr_r  <= cfg_data[lpl_pkg::THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cur_ch_r <= ch_r;
      wslot_r  <= wslot;
      rslot_r  <= rslot;
      sample_r <= in_tdata;
    end
    if (state_r == lpl_pkg::S_ENV) begin
      need_div_r <= div_start;
      if (!div_start) target_r <= lpl_pkg::UNITY_GAIN;
    end
    if (state_r == lpl_pkg::S_ACC) acc_r <= prod_r[47:24];
    if (state_r == lpl_pkg::S_DIV && div_done) target_r <= SMW'(div_quo);
    if (state_r == lpl_pkg::S_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= prod_r[46:23];
    end
  end

  assign in_tready  = (state_r == lpl_pkg::S_IDLE) && !cfg_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = (state_r == lpl_pkg::S_IDLE);

  `LPL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "word accepted while busy")
  `LPL_ASSERT_IMPL(a_div_done_waited, clk, rst_n, div_done, state_r == lpl_pkg::S_DIV, "divider result arrived outside wait")
  `LPL_ASSERT_IMPL(a_gain_bounded, clk, rst_n, state_r == lpl_pkg::S_GAIN, gain_sum <= (SMW + 1)'(lpl_pkg::UNITY_GAIN), "smoothed gain above unity")
  `LPL_ASSERT_IMPL(a_quiet_clearing, clk, rst_n, state_r == lpl_pkg::S_CLEAR, !in_tready && !out_tvalid, "traffic during ram clear")

endmodule
